// ===== design/assert_macros.svh =====
// Assertion macros used by the insertion sorter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(name, clk, rstn, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_SAME(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/isort_pkg.sv =====
// Types and constants shared by the insertion sorter modules.
package isort_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int VAL_W     = 32;

    typedef logic signed [VAL_W-1:0] val_t;

    // Input transaction payload.
    typedef struct packed {
        val_t value;
        logic last;
    } in_t;

    // Output transaction payload.
    typedef struct packed {
        val_t sorted_value;
        logic final_res;
        logic overflowed;
    } out_t;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic ins_en;
        logic drain_en;
        val_t value;
    } cell_ctrl_t;

    // What one cell shows its neighbors.
    typedef struct packed {
        val_t val;
        logic vld;
        logic gt;
    } cell_link_t;

endpackage

// ===== design/isort_cell.sv =====
// One cell of the insertion chain: holds one sorted entry.
module isort_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  isort_pkg::cell_ctrl_t  ctrl,
    input  isort_pkg::cell_link_t  lower,
    input  isort_pkg::cell_link_t  upper,
    output isort_pkg::cell_link_t  link
);
    import isort_pkg::*;

    val_t val_reg;
    val_t val_next;
    logic vld_reg;
    logic vld_next;
    logic gt;
    logic take;

    // Flag an entry strictly greater than the incoming value
    assign gt = vld_reg && ($signed(val_reg) > $signed(ctrl.value));

    // Take a value when this entry moves up or this is the first free slot
    assign take = gt || (!vld_reg && lower.vld);

    always_comb begin
        val_next = val_reg;
        vld_next = vld_reg;
        if (ctrl.drain_en) begin
            // Shift down toward the output end
            val_next = upper.val;
            vld_next = upper.vld;
        end else if (ctrl.ins_en && take) begin
            val_next = lower.gt ? lower.val : ctrl.value;
            vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        val_reg <= val_next;
    end

    assign link.val = val_reg;
    assign link.vld = vld_reg;
    assign link.gt  = gt;

endmodule

// ===== design/insertion_sorter.sv =====
// Insertion sorter top level: a chain of cells with an insert/drain sequencer.
//
//   Channel | Direction | Handshake         | Payload
//   s_      | in        | s_valid / s_ready | value, last
//   m_      | out       | m_valid / m_ready | sorted_value, final_res, overflowed
//
// An accepted input transaction is inserted into the cell chain, so a list
// streams in at one element per cycle. After the last element the chain shifts
// down one entry per cycle into the output register unless m_ready stalls it;
// s_ready is low while the list drains. A stall on m_ready freezes the chain.
// Reset is synchronous and empties every cell; no clearing pass is needed.
`include "assert_macros.svh"

module insertion_sorter (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  isort_pkg::in_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output isort_pkg::out_t  m_data
);
    import isort_pkg::*;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic       drop_reg;
    logic       drop_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    out_t       m_data_reg;
    out_t       m_data_next;

    cell_ctrl_t ctrl;
    cell_link_t links    [MAX_ITEMS];
    cell_link_t lower_in [MAX_ITEMS];
    cell_link_t upper_in [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] vld_vec;

    logic s_fire;
    logic full;
    logic adv;
    logic at_final;

    assign s_ready  = (state_reg == ST_FILL);
    assign s_fire   = s_valid && s_ready;
    assign full     = links[MAX_ITEMS-1].vld;
    assign adv      = (state_reg == ST_DRAIN) && (!m_valid_reg || m_ready);
    assign at_final = !links[1].vld;

    // Broadcast the incoming value and the phase to every cell
    assign ctrl.value    = s_data.value;
    assign ctrl.ins_en   = s_fire && !full;
    assign ctrl.drain_en = adv;

    // Wire each cell to its neighbors; the ends see fixed boundary links
    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            vld_vec[i] = links[i].vld;
            if (i == 0) begin
                lower_in[i] = '{val: '0, vld: 1'b1, gt: 1'b0};
            end else begin
                lower_in[i] = links[i-1];
            end
            if (i == MAX_ITEMS-1) begin
                upper_in[i] = '{val: '0, vld: 1'b0, gt: 1'b0};
            end else begin
                upper_in[i] = links[i+1];
            end
        end
    end

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        isort_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .lower   (lower_in[g]),
            .upper   (upper_in[g]),
            .link    (links[g])
        );
    end

    // Sequence fill and drain, and load the output register
    always_comb begin
        state_next   = state_reg;
        drop_next    = drop_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_FILL: begin
                if (s_fire) begin
                    drop_next = drop_reg || full;
                    if (s_data.last) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (adv) begin
                    m_valid_next             = 1'b1;
                    m_data_next.sorted_value = links[0].val;
                    m_data_next.final_res    = at_final;
                    m_data_next.overflowed   = drop_reg;
                    if (at_final) begin
                        state_next = ST_FILL;
                        drop_next  = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_FILL;
            drop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            drop_reg    <= drop_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Occupied cells always form one run starting at cell zero
    `ASSERT_ALWAYS(a_vld_contig, aclk, aresetn,
        (vld_vec[MAX_ITEMS-1:1] & ~vld_vec[MAX_ITEMS-2:0]) == '0,
        "cell chain has a gap")
    // Draining always has an entry at the head of the chain
    `ASSERT_SAME(a_drain_nonempty, aclk, aresetn,
        state_reg == ST_DRAIN, links[0].vld,
        "drain phase with empty chain")
    // The final result leaves the chain empty
    `ASSERT_NEXT(a_final_empties, aclk, aresetn,
        adv && at_final, vld_vec == '0,
        "chain not empty after final result")
    // An accepted element with room grows the chain by exactly one
    `ASSERT_NEXT(a_insert_grows, aclk, aresetn,
        s_fire && !full,
        $countones(vld_vec) == $past($countones(vld_vec)) + 1,
        "insert did not add one entry")

endmodule
